// ===== src/srdb_pkg.sv =====
// ---------------------------------------------------------------------------
// srdb_pkg
// Shared types and constants for the SRRIP replacement block with
// dead-block prediction.
// ---------------------------------------------------------------------------
package srdb_pkg;

    localparam int unsigned NUM_SETS_DEF        = 2048;
    localparam int unsigned NUM_WAYS_DEF        = 16;
    localparam int unsigned PRED_INDEX_BITS_DEF = 12;
    localparam int unsigned RRPV_BITS_DEF       = 2;

    // predictor index starts above the 64-byte line offset
    localparam int unsigned LINE_SHIFT  = 6;
    localparam int unsigned SIDX_W      = 11;
    localparam int unsigned WAY_W       = 4;
    localparam int unsigned ADDR_W      = 64;
    localparam int unsigned IN_TDATA_W  = 144;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // first member in the top bits, so set_index lands at bit 0 of tdata
    typedef struct packed {
        logic [ADDR_W-1:0] evict_addr;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic [WAY_W-1:0]  way;
        logic [SIDX_W-1:0] set_index;
    } item_t;

    typedef struct packed {
        logic clear;     // clearing sweep step
        logic capture;   // latch input word
        logic calc_set;  // reduce set index
        logic issue_rd;  // read row and predictor, predictor write
        logic eval;      // row data back: update write or find max
        logic age;       // aged write-back and result load
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_victim;
        logic out_full;
    } sts_t;

endpackage

// ===== src/srdb_ram.sv =====
// ---------------------------------------------------------------------------
// srdb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module srdb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/srdb_ctrl.sv =====
// ---------------------------------------------------------------------------
// srdb_ctrl
// Sequencer: clearing sweep after reset, then one word at a time through
// set reduction, memory read, evaluation and (victim requests) aging.
// ---------------------------------------------------------------------------
module srdb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           m_tready,
    input  srdb_pkg::sts_t sts,
    output srdb_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SETC  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_AGE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SETC;
                end
            end
            ST_SETC:
            begin
                cmd.calc_set = 1'b1;
                state_next   = ST_READ;
            end
            ST_READ:
            begin
                cmd.issue_rd = 1'b1;
                state_next   = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.is_victim ? ST_AGE : ST_IDLE;
            end
            ST_AGE:
            begin
                // hold until the output register can take the result
                if (!sts.out_full || m_tready)
                begin
                    cmd.age    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SETC))
        else $error("accepted word did not start processing");

    a_age_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AGE && sts.out_full && !m_tready) |=> (state_reg == ST_AGE))
        else $error("result dropped while output register full");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !cmd.capture)
        else $error("word accepted during clearing sweep");

endmodule

// ===== src/srdb_dp.sv =====
// ---------------------------------------------------------------------------
// srdb_dp
// Datapath: input latch, set reduction, RRPV row memory, dead-block table,
// row update / aging logic and the result register.
// ---------------------------------------------------------------------------
module srdb_dp #(
    parameter int unsigned NUM_SETS        = srdb_pkg::NUM_SETS_DEF,
    parameter int unsigned NUM_WAYS        = srdb_pkg::NUM_WAYS_DEF,
    parameter int unsigned PRED_INDEX_BITS = srdb_pkg::PRED_INDEX_BITS_DEF,
    parameter int unsigned RRPV_BITS       = srdb_pkg::RRPV_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  srdb_pkg::cmd_t                    cmd,
    output srdb_pkg::sts_t                    sts,
    input  srdb_pkg::item_t                   item,
    input  logic                              op,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [srdb_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int unsigned SIDX_W    = srdb_pkg::SIDX_W;
    localparam int unsigned SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned SW        = (SET_BITS > SIDX_W) ? SET_BITS : SIDX_W;
    localparam int unsigned ROW_W     = NUM_WAYS * RRPV_BITS;
    localparam int unsigned WIDX_W    = $clog2(NUM_WAYS);
    localparam int unsigned WX        = (WIDX_W > srdb_pkg::WAY_W) ? WIDX_W : srdb_pkg::WAY_W;
    localparam int unsigned PRED_SIZE = 1 << PRED_INDEX_BITS;
    localparam int unsigned CLR_DEPTH = (NUM_SETS > PRED_SIZE) ? NUM_SETS : PRED_SIZE;
    localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);
    localparam int unsigned LEVELS    = 1 << RRPV_BITS;
    localparam logic [RRPV_BITS-1:0] RRPV_TOP  = RRPV_BITS'(LEVELS - 1);
    localparam logic [RRPV_BITS-1:0] RRPV_NEAR = RRPV_BITS'(LEVELS - 2);
    // set_index mod NUM_SETS by reciprocal: exact for 11-bit operands
    localparam int unsigned RECIP_SHIFT = 2 * SIDX_W;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
    localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + NUM_SETS - 1) / NUM_SETS;
    localparam int unsigned PROD_W      = SIDX_W + RECIP_W;
    localparam int unsigned QN_W        = SIDX_W + 17;

    // latched word
    logic                       op_reg;
    logic [SIDX_W-1:0]          sidx_reg;
    logic [srdb_pkg::WAY_W-1:0] way_reg;
    logic                       hit_reg;
    logic [PRED_INDEX_BITS-1:0] aslot_reg;
    logic [PRED_INDEX_BITS-1:0] vslot_reg;
    logic                       vnz_reg;
    logic [SIDX_W-1:0]          q_reg;
    logic [SET_BITS-1:0]        set_reg;
    logic                       fwd_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [RRPV_BITS-1:0]       max_reg;
    logic [srdb_pkg::WAY_W-1:0] out_way_reg;
    logic                       m_tvalid_reg;
    logic [CLR_W-1:0]           clr_cnt_reg;

    logic [PROD_W-1:0]          prod;
    logic [QN_W-1:0]            qn;
    logic [SIDX_W-1:0]          rem;
    logic [SIDX_W-1:0]          rem_fix;
    logic [SW-1:0]              rem_ext;

    logic                       rrpv_we;
    logic [SET_BITS-1:0]        rrpv_waddr;
    logic [ROW_W-1:0]           rrpv_wdata;
    logic [ROW_W-1:0]           rrpv_rdata;
    logic                       dead_we;
    logic [PRED_INDEX_BITS-1:0] dead_waddr;
    logic                       dead_wdata;
    logic                       dead_rdata;

    logic                       clr_in_sets;
    logic                       clr_in_pred;
    logic                       dead_now;
    logic [ROW_W-1:0]           upd_row;
    logic [LEVELS-1:0]          lvl_seen;
    logic [RRPV_BITS-1:0]       max_c;
    logic [RRPV_BITS-1:0]       delta;
    logic [ROW_W-1:0]           aged_row;
    logic                       aged_top;
    logic [WIDX_W-1:0]          first_way;
    logic [WX-1:0]              first_ext;

    // ---------------- set reduction ----------------
    assign prod    = PROD_W'(item.set_index) * PROD_W'(RECIP);
    assign qn      = QN_W'(q_reg) * QN_W'(NUM_SETS);
    assign rem     = sidx_reg - qn[SIDX_W-1:0];
    assign rem_fix = (32'(rem) >= NUM_SETS) ? (rem - SIDX_W'(NUM_SETS)) : rem;
    assign rem_ext = SW'(rem_fix);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            sidx_reg  <= item.set_index;
            way_reg   <= item.way;
            hit_reg   <= item.hit;
            aslot_reg <= item.addr[srdb_pkg::LINE_SHIFT +: PRED_INDEX_BITS];
            vslot_reg <= item.evict_addr[srdb_pkg::LINE_SHIFT +: PRED_INDEX_BITS];
            vnz_reg   <= (item.evict_addr != '0);
            q_reg     <= prod[RECIP_SHIFT +: SIDX_W];
        end
        if (cmd.calc_set)
        begin
            set_reg <= rem_ext[SET_BITS-1:0];
        end
        if (cmd.issue_rd)
        begin
            // victim marking and the read of the new address hit the same slot
            fwd_reg <= !hit_reg && vnz_reg && (vslot_reg == aslot_reg);
        end
        if (cmd.eval)
        begin
            row_reg <= rrpv_rdata;
            max_reg <= max_c;
        end
        if (cmd.age)
        begin
            out_way_reg <= first_ext[srdb_pkg::WAY_W-1:0];
        end
    end

    // ---------------- clearing sweep and output valid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (cmd.age)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign clr_in_sets = (32'(clr_cnt_reg) < NUM_SETS);
    assign clr_in_pred = (32'(clr_cnt_reg) < PRED_SIZE);

    // ---------------- row logic ----------------
    assign dead_now = dead_rdata | fwd_reg;

    always_comb
    begin
        upd_row  = rrpv_rdata;
        lvl_seen = '0;
        max_c    = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (32'(way_reg) == i)
            begin
                upd_row[i*RRPV_BITS +: RRPV_BITS] = hit_reg ? '0 :
                                                    (dead_now ? RRPV_TOP : RRPV_NEAR);
            end
            lvl_seen[rrpv_rdata[i*RRPV_BITS +: RRPV_BITS]] = 1'b1;
        end
        for (int k = 0; k < LEVELS; k++)
        begin
            if (lvl_seen[k])
            begin
                max_c = RRPV_BITS'(k);
            end
        end
    end

    assign delta = RRPV_TOP - max_reg;

    always_comb
    begin
        aged_row  = '0;
        aged_top  = 1'b0;
        first_way = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            aged_row[i*RRPV_BITS +: RRPV_BITS] = row_reg[i*RRPV_BITS +: RRPV_BITS] + delta;
            if (row_reg[i*RRPV_BITS +: RRPV_BITS] == max_reg)
            begin
                first_way = WIDX_W'(i);
                aged_top  = 1'b1;
            end
        end
    end

    assign first_ext = WX'(first_way);

    // ---------------- memory ports ----------------
    always_comb
    begin
        rrpv_we    = (cmd.clear && clr_in_sets) || (cmd.eval && op_reg == srdb_pkg::OP_UPDATE)
                     || cmd.age;
        rrpv_waddr = cmd.clear ? clr_cnt_reg[SET_BITS-1:0] : set_reg;
        rrpv_wdata = cmd.clear ? '1 : (cmd.age ? aged_row : upd_row);

        dead_we    = (cmd.clear && clr_in_pred) ||
                     (cmd.issue_rd && op_reg == srdb_pkg::OP_UPDATE && (hit_reg || vnz_reg));
        dead_waddr = cmd.clear ? clr_cnt_reg[PRED_INDEX_BITS-1:0] :
                     (hit_reg ? aslot_reg : vslot_reg);
        dead_wdata = !cmd.clear && !hit_reg;
    end

    srdb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_rrpv_ram (
        .clk   (clk),
        .we    (rrpv_we),
        .waddr (rrpv_waddr),
        .wdata (rrpv_wdata),
        .raddr (set_reg),
        .rdata (rrpv_rdata)
    );

    srdb_ram #(
        .WIDTH (1),
        .DEPTH (PRED_SIZE)
    ) u_dead_ram (
        .clk   (clk),
        .we    (dead_we),
        .waddr (dead_waddr),
        .wdata (dead_wdata),
        .raddr (aslot_reg),
        .rdata (dead_rdata)
    );

    // ---------------- status and output ----------------
    assign sts.clear_last = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));
    assign sts.is_victim  = (op_reg == srdb_pkg::OP_VICTIM);
    assign sts.out_full   = m_tvalid_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = srdb_pkg::OUT_TDATA_W'(out_way_reg);

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.age |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");

    a_aged_has_top: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.age |-> aged_top)
        else $error("aged row has no way at the top RRPV");

    a_way_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (32'(out_way_reg) < NUM_WAYS))
        else $error("victim way out of range");

endmodule

// ===== src/srrip_dead_block_replacement.sv =====
// ---------------------------------------------------------------------------
// srrip_dead_block_replacement
// SRRIP replacement state with a dead-block predictor for a set-associative
// cache.
// ---------------------------------------------------------------------------
// One word at a time: s_tready is high only while the block is idle. A
// victim request's result enters the output register after set reduction,
// row read, max search and aging write-back, later while a previous result
// still sits unconsumed there. An update ends with its row write after set
// reduction and row read (its row read-modify-write). The sequencer, which
// runs each word through the registered row memory before taking the next,
// sets this order. After reset a clearing sweep that runs over all
// max(NUM_SETS, 2**PRED_INDEX_BITS) addresses (4096 by default) fills the
// RRPV memory with the top value and the predictor table with zero; no word
// is accepted until it ends. s_tuser carries op (0 victim request, 1
// update); m_tdata carries victim_way, one word per victim request.
// ---------------------------------------------------------------------------
module srrip_dead_block_replacement #(
    parameter int unsigned NUM_SETS        = srdb_pkg::NUM_SETS_DEF,
    parameter int unsigned NUM_WAYS        = srdb_pkg::NUM_WAYS_DEF,
    parameter int unsigned PRED_INDEX_BITS = srdb_pkg::PRED_INDEX_BITS_DEF,
    parameter int unsigned RRPV_BITS       = srdb_pkg::RRPV_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // set_index[10:0], way[14:11], hit[15], addr[79:16], evict_addr[143:80]
    input  logic [srdb_pkg::IN_TDATA_W-1:0]    s_tdata,
    // op[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // victim_way[3:0], zero fill [7:4]
    output logic [srdb_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    srdb_pkg::cmd_t  cmd;
    srdb_pkg::sts_t  sts;
    srdb_pkg::item_t item;

    assign item = srdb_pkg::item_t'(s_tdata);

    srdb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srdb_dp #(
        .NUM_SETS        (NUM_SETS),
        .NUM_WAYS        (NUM_WAYS),
        .PRED_INDEX_BITS (PRED_INDEX_BITS),
        .RRPV_BITS       (RRPV_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .item     (item),
        .op       (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
